[rtl/bfmv_pkg.sv]
// ----------------------------------------------------------------------------
// bfmv_pkg: shared types and constants for the batch statistics core
// Register indexes, field widths, register ranges and the config view struct.
// ----------------------------------------------------------------------------
package bfmv_pkg;

  // defaults for the top level parameters
  localparam int FEATURES_DEFAULT    = 16;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  // at most this many features are tracked
  localparam int LANES_CAP = 16;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_BATCH_SIZE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_SIZE    = 2'd2;

  // register widths and tops of their ranges
  localparam int NB_W = 9;
  localparam int NF_W = 5;
  localparam int NC_W = 11;
  localparam logic [NB_W-1:0] BATCH_TOP = 9'd256;
  localparam logic [NC_W-1:0] CLASS_TOP = 11'd1024;

  // result field widths
  localparam int IDX_W = 4;
  localparam int VAR_W = 31;

  // samples per feature n = batch * class (up to 2^18) and n*(n-1)
  localparam int N_W = 19;
  localparam int M_W = 36;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration as the back end sees it
  typedef struct packed {
    logic [NF_W-1:0] nf;     // clamped feature count
    logic [N_W-1:0]  n;      // samples per feature in one mini-batch
    logic            clear;  // register write, drop partial mini-batch
  } cfg_view_t;

endpackage

[rtl/bfmv_front.sv]
// ----------------------------------------------------------------------------
// bfmv_front: sample intake and classification
// Holds the configuration registers, tracks member, feature and batch
// position of each sample and pushes tagged samples into the queue.
// ----------------------------------------------------------------------------
module bfmv_front #(
  parameter int FEATURES    = bfmv_pkg::FEATURES_DEFAULT,
  parameter int SAMPLE_BITS = bfmv_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfmv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bfmv_pkg::CFG_DATA_W-1:0]    cfg_data,
  // incoming samples
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             in_sample,
  // queue write side
  output logic                               push,
  input  logic                               q_full,
  output logic [SAMPLE_BITS-1:0]             push_sample,
  output logic [bfmv_pkg::IDX_W-1:0]         push_feature,
  output logic                               push_last,
  // configuration for the back end
  output bfmv_pkg::cfg_view_t                cfg_view
);
  import bfmv_pkg::*;

  localparam int LANES = (FEATURES < LANES_CAP) ? FEATURES : LANES_CAP;
  localparam logic [NF_W-1:0] LANES_V = NF_W'(LANES);

  logic [NB_W-1:0] batch_size;
  logic [NF_W-1:0] feature_count;
  logic [NC_W-1:0] class_size;

  logic [NB_W-1:0] nb;
  logic [NF_W-1:0] nf;
  logic [NC_W-1:0] nc;
  logic [NB_W+NC_W-1:0] n_prod;
  logic [N_W-1:0]  n_reg;

  logic [9:0]       member_cnt;
  logic [IDX_W-1:0] feature_cnt;
  logic [7:0]       batch_cnt;
  logic [IDX_W-1:0] f_cur;
  logic member_end, feature_end, batch_end;

  logic cfg_we, cfg_listed, cfg_clear;

  // configuration channel is always ready
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid & cfg_ready;
  assign cfg_listed = (cfg_index == REG_BATCH_SIZE) || (cfg_index == REG_FEATURE_COUNT) ||
                      (cfg_index == REG_CLASS_SIZE);
  assign cfg_clear  = cfg_we & cfg_listed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size    <= NB_W'(1);
      feature_count <= NF_W'(1);
      class_size    <= NC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATCH_SIZE:    batch_size    <= cfg_data[NB_W-1:0];
        REG_FEATURE_COUNT: feature_count <= cfg_data[NF_W-1:0];
        REG_CLASS_SIZE:    class_size    <= cfg_data[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, values past the range act as the top
  always_comb begin
    nb = (batch_size == '0) ? NB_W'(1) : ((batch_size > BATCH_TOP) ? BATCH_TOP : batch_size);
    nf = (feature_count == '0) ? NF_W'(1) :
         ((feature_count > LANES_V) ? LANES_V : feature_count);
    nc = (class_size == '0) ? NC_W'(1) : ((class_size > CLASS_TOP) ? CLASS_TOP : class_size);
  end

  // samples per feature, registered
  assign n_prod = {{NC_W{1'b0}}, nb} * {{NB_W{1'b0}}, nc};

  always_ff @(posedge clk) begin
    if (rst) n_reg <= N_W'(1);
    else     n_reg <= n_prod[N_W-1:0];
  end

  always_comb begin
    cfg_view = '{nf: nf, n: n_reg, clear: cfg_clear};
  end

  // position of the current sample
  assign f_cur       = (NF_W'(feature_cnt) >= nf) ? '0 : feature_cnt;
  assign member_end  = (NC_W'(member_cnt) + NC_W'(1)) >= nc;
  assign feature_end = (NF_W'(f_cur) + NF_W'(1)) >= nf;
  assign batch_end   = (NB_W'(batch_cnt) + NB_W'(1)) >= nb;

  assign in_ready     = ~q_full;
  assign push         = in_valid & in_ready;
  assign push_sample  = in_sample;
  assign push_feature = f_cur;
  assign push_last    = member_end & feature_end & batch_end;

  // member, feature and batch counters
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      member_cnt  <= '0;
      feature_cnt <= '0;
      batch_cnt   <= '0;
    end else if (push) begin
      if (!member_end) begin
        member_cnt <= member_cnt + 10'd1;
      end else begin
        member_cnt <= '0;
        if (!feature_end) begin
          feature_cnt <= f_cur + IDX_W'(1);
        end else begin
          feature_cnt <= '0;
          if (batch_end) batch_cnt <= '0;
          else           batch_cnt <= batch_cnt + 8'd1;
        end
      end
    end
  end

endmodule

[rtl/bfmv_queue.sv]
// ----------------------------------------------------------------------------
// bfmv_queue: small first-in first-out queue
// Decouples sample intake from accumulation and the end-of-batch work.
// ----------------------------------------------------------------------------
module bfmv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bfmv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign pop_data = slots[rd_ptr];
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

endmodule

[rtl/bfmv_back.sv]
// ----------------------------------------------------------------------------
// bfmv_back: accumulation and end-of-batch statistics
// Squares and accumulates samples per feature, then for each feature runs
// shift-add products, a restoring divide for the mean and one for the
// variance, and hands the result to an output register.
// ----------------------------------------------------------------------------
module bfmv_back #(
  parameter int FEATURES    = bfmv_pkg::FEATURES_DEFAULT,
  parameter int SAMPLE_BITS = bfmv_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // queue read side
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [SAMPLE_BITS-1:0]        q_sample,
  input  logic [bfmv_pkg::IDX_W-1:0]    q_feature,
  input  logic                          q_last,
  // configuration
  input  bfmv_pkg::cfg_view_t           cfg_view,
  // result register
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfmv_pkg::IDX_W-1:0]    out_feature,
  output logic [SAMPLE_BITS-1:0]        out_mean,
  output logic [bfmv_pkg::VAR_W-1:0]    out_variance,
  output logic                          out_undefined,
  output logic                          out_last
);
  import bfmv_pkg::*;

  localparam int LANES  = (FEATURES < LANES_CAP) ? FEATURES : LANES_CAP;
  localparam int FI_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = SB + 19;
  localparam int ABS_W  = SB + 18;
  localparam int SQ_W   = 2 * SB + 17;
  localparam int PROD_W = 2 * SB + 36;
  localparam int STEP_W = $clog2(PROD_W);

  localparam logic [2:0] ST_ACCUM = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MULA  = 3'd2;
  localparam logic [2:0] ST_MULB  = 3'd3;
  localparam logic [2:0] ST_SUB   = 3'd4;
  localparam logic [2:0] ST_DIVV  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state;

  // accumulation stage
  logic [SB-1:0]    head_abs;
  logic [2*SB-1:0]  head_sq;
  logic             s1_v;
  logic [SB-1:0]    s1_x;
  logic [2*SB-1:0]  s1_sq;
  logic [IDX_W-1:0] s1_f;
  logic             s1_last;

  logic [SUM_W-1:0] sum_mem [LANES];
  logic [SQ_W-1:0]  sq_mem  [LANES];
  logic [LANES-1:0] acc_valid;
  logic [FI_W-1:0]  rd_addr;
  logic [SUM_W-1:0] rd_sum;
  logic [SQ_W-1:0]  rd_sq;

  // finishing datapath
  logic [IDX_W-1:0]   fin_idx;
  logic               s_neg;
  logic [ABS_W-1:0]   as_val, as_sh;
  logic [SQ_W-1:0]    ss_val;
  logic [N_W-1:0]     n_sh;
  logic [PROD_W-1:0]  prod_a, prod_b, d_sh;
  logic [N_W-1:0]     mrem;
  logic [ABS_W-1:0]   mq;
  logic [M_W-1:0]     vrem;
  logic [VAR_W-1:0]   vq;
  logic               vsat;
  logic [STEP_W-1:0]  step;

  logic [SUM_W-1:0]   sum_neg;
  logic [ABS_W-1:0]   load_abs;
  logic [PROD_W-1:0]  mula_add, mulb_add;
  logic [N_W:0]       mrem_sh, mrem_sub;
  logic               mfit;
  logic [PROD_W:0]    diff;
  logic [M_W:0]       vrem_sh, vrem_sub;
  logic               vfit;
  logic [SB-1:0]      mean_mag, mean_res;
  logic [VAR_W-1:0]   var_res;
  logic               last_feat, out_free;

  logic [2*N_W-1:0]   m_prod;
  logic [M_W-1:0]     m_reg;
  logic               n_one;

  // n*(n-1), registered; the user must keep the configuration stable while a batch runs, the block does not enforce it
  assign m_prod = {{N_W{1'b0}}, cfg_view.n} * {{N_W{1'b0}}, cfg_view.n - N_W'(1)};

  always_ff @(posedge clk) begin
    m_reg <= m_prod[M_W-1:0];
    n_one <= (cfg_view.n == N_W'(1));
  end

  // square of the queue head
  assign head_abs = q_sample[SB-1] ? (~q_sample + SB'(1)) : q_sample;
  assign head_sq  = {{SB{1'b0}}, head_abs} * {{SB{1'b0}}, head_abs};
  assign q_pop    = (state == ST_ACCUM) && !q_empty && !(s1_v && s1_last);

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_x    <= q_sample;
      s1_sq   <= head_sq;
      s1_f    <= q_feature;
      s1_last <= q_last;
    end
  end

  // accumulator read, entries not yet written read as zero
  assign rd_addr = (state == ST_ACCUM) ? s1_f[FI_W-1:0] : fin_idx[FI_W-1:0];
  assign rd_sum  = acc_valid[rd_addr] ? sum_mem[rd_addr] : '0;
  assign rd_sq   = acc_valid[rd_addr] ? sq_mem[rd_addr] : '0;

  always_ff @(posedge clk) begin
    if (s1_v) begin
      sum_mem[rd_addr] <= rd_sum + {{(SUM_W-SB){s1_x[SB-1]}}, s1_x};
      sq_mem[rd_addr]  <= rd_sq + SQ_W'(s1_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_view.clear) begin
      acc_valid <= '0;
    end else if (s1_v) begin
      acc_valid[rd_addr] <= 1'b1;
    end else if (state == ST_LOAD) begin
      acc_valid[rd_addr] <= 1'b0;
    end
  end

  // finishing arithmetic
  assign sum_neg  = '0 - rd_sum;
  assign load_abs = rd_sum[SUM_W-1] ? sum_neg[ABS_W-1:0] : rd_sum[ABS_W-1:0];
  assign mula_add = n_sh[N_W-1] ? PROD_W'(ss_val) : '0;
  assign mulb_add = as_sh[ABS_W-1] ? PROD_W'(as_val) : '0;

  assign mrem_sh  = {mrem, as_sh[ABS_W-1]};
  assign mfit     = mrem_sh >= {1'b0, cfg_view.n};
  assign mrem_sub = mrem_sh - {1'b0, cfg_view.n};

  assign diff     = {1'b0, prod_a} - {1'b0, prod_b};

  assign vrem_sh  = {vrem, d_sh[PROD_W-1]};
  assign vfit     = vrem_sh >= {1'b0, m_reg};
  assign vrem_sub = vrem_sh - {1'b0, m_reg};

  assign mean_mag  = mq[SB-1:0];
  assign mean_res  = s_neg ? (~mean_mag + SB'(1)) : mean_mag;
  assign var_res   = n_one ? '0 : (vsat ? '1 : vq);
  assign last_feat = (NF_W'(fin_idx) + NF_W'(1)) == cfg_view.nf;
  assign out_free  = !out_valid || out_ready;

  // sequencer over features at batch end
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_ACCUM;
      fin_idx <= '0;
    end else begin
      unique case (state)
        ST_ACCUM: begin
          if (s1_v && s1_last) state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_MULA;
        end
        ST_MULA: begin
          if (step == '0) state <= ST_MULB;
        end
        ST_MULB: begin
          if (step == '0) state <= ST_SUB;
        end
        ST_SUB: begin
          state <= n_one ? ST_EMIT : ST_DIVV;
        end
        ST_DIVV: begin
          if (step == '0) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last_feat) begin
              state   <= ST_ACCUM;
              fin_idx <= '0;
            end else begin
              state   <= ST_LOAD;
              fin_idx <= fin_idx + IDX_W'(1);
            end
          end
        end
        default: state <= ST_ACCUM;
      endcase
    end
  end

  // shift-add products and restoring divides
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        s_neg  <= rd_sum[SUM_W-1];
        as_val <= load_abs;
        as_sh  <= load_abs;
        ss_val <= rd_sq;
        n_sh   <= cfg_view.n;
        prod_a <= '0;
        prod_b <= '0;
        mrem   <= '0;
        mq     <= '0;
        step   <= STEP_W'(N_W - 1);
      end
      ST_MULA: begin
        // n * sum of squares, one bit of n per cycle
        prod_a <= {prod_a[PROD_W-2:0], 1'b0} + mula_add;
        n_sh   <= {n_sh[N_W-2:0], 1'b0};
        step   <= (step == '0) ? STEP_W'(ABS_W - 1) : step - STEP_W'(1);
      end
      ST_MULB: begin
        // sum squared and |sum| / n share the bit stream of |sum|
        prod_b <= {prod_b[PROD_W-2:0], 1'b0} + mulb_add;
        mrem   <= mfit ? mrem_sub[N_W-1:0] : mrem_sh[N_W-1:0];
        mq     <= {mq[ABS_W-2:0], mfit};
        as_sh  <= {as_sh[ABS_W-2:0], 1'b0};
        step   <= step - STEP_W'(1);
      end
      ST_SUB: begin
        d_sh <= diff[PROD_W] ? '0 : diff[PROD_W-1:0];
        vrem <= '0;
        vq   <= '0;
        vsat <= 1'b0;
        step <= STEP_W'(PROD_W - 1);
      end
      ST_DIVV: begin
        // quotient bits leaving the top of the window saturate the result
        vrem <= vfit ? vrem_sub[M_W-1:0] : vrem_sh[M_W-1:0];
        vq   <= {vq[VAR_W-2:0], vfit};
        vsat <= vsat | vq[VAR_W-1];
        d_sh <= {d_sh[PROD_W-2:0], 1'b0};
        step <= step - STEP_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_feature   <= fin_idx;
      out_mean      <= mean_res;
      out_variance  <= var_res;
      out_undefined <= n_one;
      out_last      <= last_feat;
    end
  end

endmodule

[rtl/batch_feature_mean_variance_core.sv]
// ----------------------------------------------------------------------------
// batch_feature_mean_variance_core: per-feature mean and variance of a batch
// Accumulates signed samples per feature and emits mean and unbiased
// variance for every feature at the end of each mini-batch.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while a mini-batch streams in.
// After the last sample the features are finished one at a time by the
//   bit-serial products and the restoring divides, one bit a cycle; the
//   variance divide is skipped when n is 1.
// Intake stalls at batch end once the four-entry queue fills.
// Reset (rst, synchronous): registers to 1, accumulators and counters clear.
module batch_feature_mean_variance_core #(
  parameter int FEATURES    = bfmv_pkg::FEATURES_DEFAULT,
  parameter int SAMPLE_BITS = bfmv_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfmv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfmv_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // feature_index, mean_value, variance_value
  output logic [((SAMPLE_BITS+42)/8)*8-1:0] m_tdata,
  // variance_undefined
  output logic                             m_tuser,
  // final_feature
  output logic                             m_tlast
);
  import bfmv_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 42) / 8) * 8;
  localparam int Q_W   = SAMPLE_BITS + IDX_W + 1;

  cfg_view_t              cfg_view;
  logic                   push, q_full, q_pop, q_empty;
  logic [SAMPLE_BITS-1:0] push_sample, q_sample;
  logic [IDX_W-1:0]       push_feature, q_feature;
  logic                   push_last, q_last;
  logic [Q_W-1:0]         q_pop_data;

  logic [IDX_W-1:0]       res_feature;
  logic [SAMPLE_BITS-1:0] res_mean;
  logic [VAR_W-1:0]       res_variance;

  // intake and classification
  bfmv_front #(
    .FEATURES    (FEATURES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_sample    (s_tdata[SAMPLE_BITS-1:0]),
    .push         (push),
    .q_full       (q_full),
    .push_sample  (push_sample),
    .push_feature (push_feature),
    .push_last    (push_last),
    .cfg_view     (cfg_view)
  );

  // queue between intake and back end
  bfmv_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_last, push_feature, push_sample}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  assign q_sample  = q_pop_data[SAMPLE_BITS-1:0];
  assign q_feature = q_pop_data[SAMPLE_BITS +: IDX_W];
  assign q_last    = q_pop_data[Q_W-1];

  // accumulation and statistics
  bfmv_back #(
    .FEATURES    (FEATURES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_sample      (q_sample),
    .q_feature     (q_feature),
    .q_last        (q_last),
    .cfg_view      (cfg_view),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_feature   (res_feature),
    .out_mean      (res_mean),
    .out_variance  (res_variance),
    .out_undefined (m_tuser),
    .out_last      (m_tlast)
  );

  // result packing, lowest field first
  assign m_tdata = OUT_W'({res_variance, res_mean, res_feature});

endmodule

[rtl/bfmv_checker.sv]
// ----------------------------------------------------------------------------
// bfmv_checker: port-level checks for the batch statistics core
// Watches the result stream for reset, stall, flag and ordering rules.
// ----------------------------------------------------------------------------
module bfmv_checker #(
  parameter int SAMPLE_BITS = bfmv_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((SAMPLE_BITS+42)/8)*8-1:0] m_tdata,
  input logic                              m_tuser,
  input logic                              m_tlast
);
  import bfmv_pkg::*;

  localparam int VAR_LSB = SAMPLE_BITS + IDX_W;
  localparam int VAR_MSB = VAR_LSB + VAR_W - 1;

  logic [IDX_W-1:0] next_idx;

  // expected feature index of the next result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      next_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      next_idx <= m_tlast ? '0 : m_tdata[IDX_W-1:0] + IDX_W'(1);
    end
  end

  // no result is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                             $stable(m_tlast))
    else $error("stalled result changed");

  // an undefined variance is reported as zero
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[VAR_MSB:VAR_LSB] == '0)
    else $error("undefined variance not zero");

  // results come in feature order, restarting after the last feature
  a_feature_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |-> m_tdata[IDX_W-1:0] == next_idx)
    else $error("result out of feature order");

endmodule

bind batch_feature_mean_variance_core bfmv_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bfmv_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);

[tb/batch_feature_mean_variance_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_feature_mean_variance_core_test: self-checking bench for the core
// Streams mini-batches of Q8.8 samples under several register settings and
// compares every per-feature mean/variance result with a cycle-free model.
// ----------------------------------------------------------------------------
module batch_feature_mean_variance_core_test;
  import bfmv_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int RES_W = ((SAMPLE_W + 42) / 8) * 8;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  // generous bound, well above the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;
  // quiet cycles after the last result, covers the back end latency
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD = 3000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata;    // sample
  logic                   m_tvalid;
  logic                   m_tready;
  logic [RES_W-1:0]       m_tdata;    // feature_index, mean_value, variance_value
  logic                   m_tuser;    // variance_undefined
  logic                   m_tlast;    // final_feature

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int cycle_count;

  typedef struct {
    logic [IDX_W-1:0]        feature;
    logic signed [SAMPLE_W-1:0] mean;
    logic [VAR_W-1:0]        variance;
    logic                    undefined;
    logic                    last;
  } feature_stats_t;

  // per-feature statistics model and store of expected results
  class mean_variance_scoreboard;
    logic [NB_W-1:0] batch_reg;
    logic [NF_W-1:0] feature_reg;
    logic [NC_W-1:0] class_reg;
    longint          sums[LANES_CAP];
    bit [63:0]       square_sums[LANES_CAP];
    int              member_cnt;
    int              feature_cnt;
    int              batch_cnt;
    feature_stats_t  expected_stats[$];
    int              errors;

    function new();
      batch_reg = 1;
      feature_reg = 1;
      class_reg = 1;
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (sums[k]) begin
        sums[k] = 0;
        square_sums[k] = 0;
      end
      member_cnt = 0;
      feature_cnt = 0;
      batch_cnt = 0;
    endfunction

    // zero acts as one, above range acts as the top
    function int clamp(int v, int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int minibatch_length();
      return clamp(batch_reg, 256) * clamp(feature_reg, LANES_CAP) * clamp(class_reg, 1024);
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BATCH_SIZE:    batch_reg = data[NB_W-1:0];
        REG_FEATURE_COUNT: feature_reg = data[NF_W-1:0];
        REG_CLASS_SIZE:    class_reg = data[NC_W-1:0];
        default:           return;
      endcase
      clear();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw);
      int nb, nf, nc, n, f;
      longint x, s, avg;
      bit [63:0] mag;
      bit [127:0] pos, neg, num, quo;
      feature_stats_t r;
      nb = clamp(batch_reg, 256);
      nf = clamp(feature_reg, LANES_CAP);
      nc = clamp(class_reg, 1024);
      x = longint'($signed(raw));
      f = (feature_cnt >= nf) ? 0 : feature_cnt;
      sums[f] += x;
      square_sums[f] += 64'(x * x);
      if (member_cnt + 1 < nc) begin
        member_cnt++;
        return;
      end
      member_cnt = 0;
      if (f + 1 < nf) begin
        feature_cnt = f + 1;
        return;
      end
      feature_cnt = 0;
      if (batch_cnt + 1 < nb) begin
        batch_cnt++;
        return;
      end
      // mini-batch complete: exact mean and unbiased variance per feature
      n = nb * nc;
      for (int k = 0; k < nf; k++) begin
        s = sums[k];
        avg = s / longint'(n);
        r.feature = 4'(k);
        r.mean = avg[SAMPLE_W-1:0];
        r.variance = '0;
        r.undefined = 1'b1;
        if (n > 1) begin
          mag = (s < 0) ? 64'(-s) : 64'(s);
          pos = 128'(n) * 128'(square_sums[k]);
          neg = 128'(mag) * 128'(mag);
          num = (pos > neg) ? pos - neg : '0;
          quo = num / (128'(n) * 128'(n - 1));
          r.variance = (quo > 128'h7FFFFFFF) ? 31'h7FFFFFFF : quo[VAR_W-1:0];
          r.undefined = 1'b0;
        end
        r.last = (k == nf - 1);
        expected_stats.push_back(r);
      end
      clear();
    endfunction

    function void mismatch(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(logic [RES_W-1:0] data, logic undefined, logic last);
      feature_stats_t want;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result, expected none actual tdata=%h", $time, data);
        errors++;
        return;
      end
      want = expected_stats.pop_front();
      if (data[3:0] !== want.feature) mismatch("feature_index", want.feature, data[3:0]);
      if (data[19:4] !== want.mean)
        mismatch("mean_value", want.mean, longint'($signed(data[19:4])));
      if (data[50:20] !== want.variance) mismatch("variance_value", want.variance, data[50:20]);
      if (undefined !== want.undefined) mismatch("variance_undefined", want.undefined, undefined);
      if (last !== want.last) mismatch("final_feature", want.last, last);
    endfunction
  endclass

  mean_variance_scoreboard sb = new();

  batch_feature_mean_variance_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run bound
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side ready, with random idling and long hold-offs on request
  initial begin : result_sink
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result transaction check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // random sample, biased toward extremes and small values
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // small register value, zero now and then
  function automatic logic [CFG_DATA_W-1:0] pick_size(int top);
    if ($urandom_range(7) == 0) return '0;
    return CFG_DATA_W'($urandom_range(1, top));
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(value);
  endtask

  // stop sending and wait until every expected result is in
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_register(idx, data);
  endtask

  task automatic run_minibatches(input int nb, input int nf, input int nc, input int count);
    int total;
    write_reg(REG_BATCH_SIZE, CFG_DATA_W'(nb));
    write_reg(REG_FEATURE_COUNT, CFG_DATA_W'(nf));
    write_reg(REG_CLASS_SIZE, CFG_DATA_W'(nc));
    total = sb.minibatch_length() * count;
    repeat (total) send_sample(pick_sample());
  endtask

  // random settings, whole mini-batches with an occasional broken one
  task automatic random_traffic(input int target);
    int sent;
    int count;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(2) != 0) write_reg(REG_BATCH_SIZE, pick_size(4));
      if ($urandom_range(2) != 0) begin
        if ($urandom_range(9) == 0) write_reg(REG_FEATURE_COUNT, 11'($urandom_range(5, 31)));
        else write_reg(REG_FEATURE_COUNT, pick_size(4));
      end
      if ($urandom_range(2) != 0) write_reg(REG_CLASS_SIZE, pick_size(4));
      if ($urandom_range(15) == 0) write_reg(REG_UNUSED, 11'($urandom));
      count = sb.minibatch_length() * $urandom_range(1, 3);
      if ($urandom_range(7) == 0) count += $urandom_range(1, sb.minibatch_length());
      // stay within the sample budget of this phase
      if (count > target - sent) count = target - sent;
      repeat (count) send_sample(pick_sample());
      sent += count;
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_requests = 0;
    send_idle_pct = 27;
    recv_idle_pct = 67;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings give one sample per feature: variance undefined
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hffff);

    // opposite extremes in two features over two batch entries
    write_reg(REG_BATCH_SIZE, 11'd2);
    write_reg(REG_FEATURE_COUNT, 11'd2);
    write_reg(REG_CLASS_SIZE, 11'd1);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    send_sample(16'h8000);

    // zero register values act as one
    write_reg(REG_BATCH_SIZE, 11'd0);
    write_reg(REG_FEATURE_COUNT, 11'd0);
    write_reg(REG_CLASS_SIZE, 11'd0);
    send_sample(16'h1234);

    // a write drops the partial mini-batch; negative mean truncates toward zero
    write_reg(REG_CLASS_SIZE, 11'd3);
    send_sample(16'd100);
    send_sample(16'd200);
    write_reg(REG_CLASS_SIZE, 11'd2);
    send_sample(16'hfffd);
    send_sample(16'h0000);

    // unknown register index leaves the partial sums alone
    write_reg(REG_CLASS_SIZE, 11'd3);
    send_sample(16'd5);
    send_sample(16'd6);
    write_reg(REG_UNUSED, 11'h7ff);
    send_sample(16'd7);

    random_traffic(85);

    // receiver holds off while full 16-feature batches keep coming
    write_reg(REG_CLASS_SIZE, 11'd1);
    hold_requests++;
    run_minibatches(1, 31, 1, 2);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 27;
    random_traffic(85);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(85);

    // all sixteen features in one batch entry
    run_minibatches(1, 16, 1, 1);

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bfmv_pkg.sv
rtl/bfmv_front.sv
rtl/bfmv_queue.sv
rtl/bfmv_back.sv
rtl/batch_feature_mean_variance_core.sv
rtl/bfmv_checker.sv
tb/batch_feature_mean_variance_core_test.sv
